/* sv/wstd_pkg.sv */
// Shared types and constants of the work-stealing task dispatcher.
`timescale 1ns / 1ps

package wstd_pkg;

   localparam int WORKERS_DEFAULT   = 8;
   localparam int TASK_BITS_DEFAULT = 16;

   localparam logic [3:0] WORKER_COUNT_RESET = 4'd8;

   typedef enum logic [1:0] {
      STATUS_GRANT    = 2'd0,
      STATUS_FINISHED = 2'd1,
      STATUS_STARTED  = 2'd2,
      STATUS_REJECTED = 2'd3
   } status_type;

   typedef enum logic {
      FUNC_START   = 1'b0,
      FUNC_REQUEST = 1'b1
   } func_type;

   typedef struct packed {
      func_type    func;
      logic [2:0]  worker;
      logic [15:0] task_count;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic [15:0] task_id;
      logic        job_idle;
   } rsp_type;

endpackage

/* sv/work_stealing_task_dispatcher_unit.sv */
// Top level of the work-stealing task dispatcher: sequencer, shared divider and steal scan.
`timescale 1ns / 1ps

// Channel    | Ports                    | Handshake
// -----------+--------------------------+------------------------------------------
// request    | start, busy, req_item    | taken at an edge with start high, busy low
// result     | rsp_valid, rsp_item      | one-cycle strobe, always taken
// config     | csr_we, csr_wdata        | worker_count written when csr_we is high
//
// A rejected request or an empty job answers in the cycle after it is taken. A job
// start runs the shared subtract/compare unit once per task-count bit to divide the
// job, then walks the active workers one per cycle. A task request scans one
// candidate worker per cycle.
// The result strobe rises in the cycle busy falls; the receiver never stalls.
// Reset (synchronous) marks every worker idle and sets worker_count to 8.

module work_stealing_task_dispatcher_unit #(
   parameter int WORKERS   = wstd_pkg::WORKERS_DEFAULT,
   parameter int TASK_BITS = wstd_pkg::TASK_BITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  wstd_pkg::req_type req_item,
   output logic              rsp_valid,
   output wstd_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata
);

   // Worker index width, and count width (holds WORKERS itself).
   localparam int IW  = (WORKERS > 1) ? $clog2(WORKERS) : 1;
   localparam int CW  = $clog2(WORKERS + 1);
   // Division bit counter width.
   localparam int DCW = $clog2(TASK_BITS);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_SCAN
   } state_type;

   state_type state_ff, state_in;

   logic [3:0] worker_count_ff, worker_count_in;

   // Per-worker ranges [next_task, range_end) and steal progress.
   logic [TASK_BITS-1:0] next_task_ff [WORKERS];
   logic [TASK_BITS-1:0] next_task_in [WORKERS];
   logic [TASK_BITS-1:0] range_end_ff [WORKERS];
   logic [TASK_BITS-1:0] range_end_in [WORKERS];
   logic [CW-1:0]        steal_off_ff [WORKERS];
   logic [CW-1:0]        steal_off_in [WORKERS];
   logic [WORKERS-1:0]   busy_vec_ff, busy_vec_in;
   logic [CW-1:0]        active_ff, active_in;

   // Shared divider: quotient shifts in from the dividend, remainder beside it.
   logic [TASK_BITS-1:0] quot_ff, quot_in;
   logic [CW-1:0]        rem_ff, rem_in;
   logic [DCW-1:0]       bit_cnt_ff, bit_cnt_in;

   // Range walk.
   logic [CW-1:0]        idx_ff, idx_in;
   logic [TASK_BITS-1:0] pos_ff, pos_in;

   // Steal scan.
   logic [IW-1:0]        wkr_ff, wkr_in;
   logic [IW-1:0]        victim_ff, victim_in;
   logic [CW-1:0]        off_ff, off_in;

   logic              rsp_valid_ff, rsp_valid_in;
   wstd_pkg::rsp_type rsp_ff, rsp_in;

   // Request decode helpers.
   logic                 accept;
   logic [TASK_BITS-1:0] req_tasks;
   logic [CW-1:0]        eff_workers;
   logic [CW-1:0]        req_active;
   logic [IW-1:0]        req_wkr;
   logic                 req_ok;
   logic [CW:0]          start_sum;

   // Shared arithmetic terms.
   logic [CW:0]          div_trial;
   logic                 div_fits;
   logic                 hit;
   logic [CW-1:0]        victim_next;

   assign accept    = start && (state_ff == ST_IDLE);
   assign req_tasks = TASK_BITS'(req_item.task_count);
   assign req_wkr   = IW'(req_item.worker);

   // Clamp worker_count to 1..WORKERS, then limit it by the task count.
   always_comb begin
      if (worker_count_ff == 4'd0) begin
         eff_workers = CW'(1);
      end else if (32'(worker_count_ff) > WORKERS) begin
         eff_workers = CW'(WORKERS);
      end else begin
         eff_workers = CW'(worker_count_ff);
      end
      if (32'(req_tasks) < 32'(eff_workers)) begin
         req_active = CW'(req_tasks);
      end else begin
         req_active = eff_workers;
      end
   end

   assign req_ok    = (32'(req_item.worker) < WORKERS) && busy_vec_ff[req_wkr];
   // First victim: (worker + offset) mod active, with both terms below active.
   assign start_sum = (CW+1)'(req_wkr) + (CW+1)'(steal_off_ff[req_wkr]);

   assign div_trial   = {rem_ff, quot_ff[TASK_BITS-1]};
   assign div_fits    = div_trial >= {1'b0, active_ff};
   assign hit         = ((off_ff == '0) || busy_vec_ff[victim_ff])
                        && (next_task_ff[victim_ff] < range_end_ff[victim_ff]);
   assign victim_next = ((CW'(victim_ff) + CW'(1)) == active_ff) ? '0
                        : (CW'(victim_ff) + CW'(1));

   always_comb begin
      state_in        = state_ff;
      worker_count_in = csr_we ? csr_wdata : worker_count_ff;
      next_task_in    = next_task_ff;
      range_end_in    = range_end_ff;
      steal_off_in    = steal_off_ff;
      busy_vec_in     = busy_vec_ff;
      active_in       = active_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      bit_cnt_in      = bit_cnt_ff;
      idx_in          = idx_ff;
      pos_in          = pos_ff;
      wkr_in          = wkr_ff;
      victim_in       = victim_ff;
      off_in          = off_ff;
      rsp_valid_in    = 1'b0;
      rsp_in          = rsp_ff;
      rsp_in.task_id  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.func == wstd_pkg::FUNC_START) begin
                  if (|busy_vec_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = wstd_pkg::STATUS_REJECTED;
                  end else begin
                     // Drop the old job; workers come up during the walk.
                     busy_vec_in = '0;
                     for (int i = 0; i < WORKERS; i++) begin
                        steal_off_in[i] = '0;
                     end
                     active_in = req_active;
                     if (req_active == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = wstd_pkg::STATUS_STARTED;
                     end else begin
                        quot_in    = req_tasks;
                        rem_in     = '0;
                        bit_cnt_in = DCW'(TASK_BITS - 1);
                        state_in   = ST_DIV;
                     end
                  end
               end else begin
                  if (!req_ok) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = wstd_pkg::STATUS_REJECTED;
                  end else begin
                     wkr_in = req_wkr;
                     off_in = steal_off_ff[req_wkr];
                     if (start_sum >= {1'b0, active_ff}) begin
                        victim_in = IW'(start_sum - {1'b0, active_ff});
                     end else begin
                        victim_in = IW'(start_sum);
                     end
                     state_in = ST_SCAN;
                  end
               end
            end
         end

         ST_DIV: begin
            // One restoring division step per cycle.
            if (div_fits) begin
               rem_in = CW'(div_trial - {1'b0, active_ff});
            end else begin
               rem_in = CW'(div_trial);
            end
            quot_in = {quot_ff[TASK_BITS-2:0], div_fits};
            if (bit_cnt_ff == '0) begin
               idx_in   = '0;
               pos_in   = '0;
               state_in = ST_WALK;
            end else begin
               bit_cnt_in = bit_cnt_ff - DCW'(1);
            end
         end

         ST_WALK: begin
            // Hand worker idx its range; the first 'remainder' workers get one more.
            pos_in = pos_ff + quot_ff + TASK_BITS'(idx_ff < rem_ff);
            next_task_in[idx_ff[IW-1:0]] = pos_ff;
            range_end_in[idx_ff[IW-1:0]] = pos_in;
            busy_vec_in[idx_ff[IW-1:0]]  = 1'b1;
            if ((idx_ff + CW'(1)) == active_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = wstd_pkg::STATUS_STARTED;
               state_in      = ST_IDLE;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         ST_SCAN: begin
            if (hit) begin
               next_task_in[victim_ff] = next_task_ff[victim_ff] + TASK_BITS'(1);
               steal_off_in[wkr_ff]    = off_ff;
               rsp_valid_in            = 1'b1;
               rsp_in.status           = wstd_pkg::STATUS_GRANT;
               rsp_in.task_id          = 16'(next_task_ff[victim_ff]);
               state_in                = ST_IDLE;
            end else if ((off_ff + CW'(1)) == active_ff) begin
               steal_off_in[wkr_ff] = '0;
               busy_vec_in[wkr_ff]  = 1'b0;
               rsp_valid_in         = 1'b1;
               rsp_in.status        = wstd_pkg::STATUS_FINISHED;
               state_in             = ST_IDLE;
            end else begin
               off_in    = off_ff + CW'(1);
               victim_in = IW'(victim_next);
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_in.job_idle = ~|busy_vec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         worker_count_ff <= wstd_pkg::WORKER_COUNT_RESET;
         busy_vec_ff     <= '0;
         active_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < WORKERS; i++) begin
            steal_off_ff[i] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         worker_count_ff <= worker_count_in;
         busy_vec_ff     <= busy_vec_in;
         active_ff       <= active_in;
         rsp_valid_ff    <= rsp_valid_in;
         steal_off_ff    <= steal_off_in;
      end
      next_task_ff <= next_task_in;
      range_end_ff <= range_end_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      wkr_ff       <= wkr_in;
      victim_ff    <= victim_in;
      off_ff       <= off_in;
      rsp_ff       <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   // A result appears only while the sequencer is idle.
   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Every accepted request either answers at once or keeps the block busy.
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_valid || busy))
      else $error("accepted request neither answered nor in progress");

   // The granted worker stays busy, so the job cannot be idle.
   a_grant_not_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status == wstd_pkg::STATUS_GRANT) |-> !rsp_item.job_idle)
      else $error("grant reported with job idle");

   // No worker outside the active set is ever busy.
   a_busy_in_range: assert property (@(posedge clock) disable iff (reset)
      (32'(busy_vec_ff) >> active_ff) == 32'd0)
      else $error("busy worker beyond active count");
`endif

endmodule

/* tb/sv/dispatch_checker.sv */
// Checker for the work-stealing task dispatcher: mirrors its state and compares every result.
`timescale 1ns / 1ps

module dispatch_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  wstd_pkg::req_type req_item,
   input  logic              rsp_valid,
   input  wstd_pkg::rsp_type rsp_item,
   input  logic              csr_we,
   input  logic [3:0]        csr_wdata,
   output int                fail_count,
   output int                awaiting
);
   import wstd_pkg::*;

   localparam int CREW_MAX = WORKERS_DEFAULT;

   logic [3:0]  cfg_workers;
   logic [15:0] next_id   [CREW_MAX];
   logic [15:0] stop_id   [CREW_MAX];
   logic        on_duty   [CREW_MAX];
   int unsigned steal_hop [CREW_MAX];
   int unsigned crew;
   rsp_type     due_rsp [$];

   function automatic logic everyone_idle();
      for (int i = 0; i < CREW_MAX; i++)
         if (on_duty[i]) return 1'b0;
      return 1'b1;
   endfunction

   function automatic void clear_crew();
      for (int i = 0; i < CREW_MAX; i++) begin
         next_id[i]   = '0;
         stop_id[i]   = '0;
         on_duty[i]   = 1'b0;
         steal_hop[i] = 0;
      end
   endfunction

   // Work out the result of one request and advance the mirrored state.
   function automatic rsp_type dispatch_outcome(req_type r);
      rsp_type     res;
      int unsigned eff, share, spare, mark, hop, victim, w, tasks;
      logic        found;
      res.status  = STATUS_REJECTED;
      res.task_id = '0;
      tasks = r.task_count;
      w     = r.worker;
      if (r.func == FUNC_START) begin
         if (everyone_idle()) begin
            clear_crew();
            eff = (cfg_workers == 0) ? 1 : (cfg_workers > CREW_MAX) ? CREW_MAX : cfg_workers;
            crew = (tasks < eff) ? tasks : eff;
            if (crew != 0) begin
               share = tasks / crew;
               spare = tasks % crew;
               mark  = 0;
               for (int i = 0; i < crew; i++) begin
                  next_id[i] = 16'(mark);
                  mark = (mark + share + ((i < spare) ? 1 : 0)) & 32'hFFFF;
                  stop_id[i] = 16'(mark);
                  on_duty[i] = 1'b1;
               end
            end
            res.status = STATUS_STARTED;
         end
      end else if (w < crew && on_duty[w]) begin
         found = 1'b0;
         for (hop = steal_hop[w]; hop < crew && !found; hop++) begin
            victim = (w + hop) % crew;
            if ((hop == 0 || on_duty[victim]) && next_id[victim] < stop_id[victim]) begin
               res.task_id     = next_id[victim];
               next_id[victim] = next_id[victim] + 16'd1;
               steal_hop[w]    = hop;
               found           = 1'b1;
            end
         end
         if (found) begin
            res.status = STATUS_GRANT;
         end else begin
            steal_hop[w] = 0;
            on_duty[w]   = 1'b0;
            res.status   = STATUS_FINISHED;
         end
      end
      res.job_idle = everyone_idle();
      return res;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         fail_count++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      rsp_type want;
      if (reset) begin
         cfg_workers = WORKER_COUNT_RESET;
         clear_crew();
         crew = 0;
         due_rsp.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (due_rsp.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected result: expected none, actual status %0d task %0d idle %0d",
                        $time, rsp_item.status, rsp_item.task_id, rsp_item.job_idle);
            end else begin
               want = due_rsp.pop_front();
               check_field("status", want.status, rsp_item.status);
               check_field("task_id", want.task_id, rsp_item.task_id);
               check_field("job_idle", want.job_idle, rsp_item.job_idle);
            end
         end
         if (start && !busy)
            due_rsp.push_back(dispatch_outcome(req_item));
         if (csr_we)
            cfg_workers = csr_wdata;
      end
      awaiting = due_rsp.size();
   end

endmodule

/* tb/sv/testbench.sv */
// Top of the dispatcher testbench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;
   import wstd_pkg::*;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        start     = 1'b0;
   req_type     req_item  = '0;
   logic        csr_we    = 1'b0;
   logic [3:0]  csr_wdata = '0;
   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_item;
   int          fail_count;
   int          awaiting;

   // Acceptance and job-idle flags, captured at the rising edge and read at the falling one.
   logic        took      = 1'b0;
   logic        idle_seen = 1'b1;

   logic [3:0]  worker_setting = WORKER_COUNT_RESET;
   logic [3:0]  cfg_plan [0:10];
   logic        calm = 1'b0;     // set for the last stretch: no gaps between requests
   int unsigned sent = 0;

   always #2 clock = ~clock;

   work_stealing_task_dispatcher_unit uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   dispatch_checker watch (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_valid  (rsp_valid),
      .rsp_item   (rsp_item),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .awaiting   (awaiting)
   );

   // Record at each rising edge whether the request on the port was taken,
   // and keep the job_idle flag of the latest result for steering the stimulus.
   always @(posedge clock) begin
      took <= start && !busy;
      if (rsp_valid)
         idle_seen <= rsp_item.job_idle;
   end

   // Build a job start; the unused worker field carries noise.
   function automatic req_type job(logic [15:0] count);
      req_type r;
      r.func       = FUNC_START;
      r.worker     = 3'($urandom);
      r.task_count = count;
      return r;
   endfunction

   // Build a task request; the unused task count carries noise.
   function automatic req_type ask(logic [2:0] who);
      req_type r;
      r.func       = FUNC_REQUEST;
      r.worker     = who;
      r.task_count = 16'($urandom);
      return r;
   endfunction

   // Present one request at the falling edge and hold it until taken. Leave start high
   // afterwards so the next request follows back to back, or drop it for a random gap.
   task automatic issue(req_type r);
      start    <= 1'b1;
      req_item <= r;
      @(negedge clock);
      while (!took) @(negedge clock);
      sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   // Drop start and wait until every outstanding result has come back.
   task automatic settle();
      start <= 1'b0;
      @(negedge clock);
      while (awaiting != 0) @(negedge clock);
   endtask

   // Write the worker count while the block is idle.
   task automatic set_workers(logic [3:0] value);
      settle();
      csr_we         <= 1'b1;
      csr_wdata      <= value;
      worker_setting  = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // Keep requesting tasks in small bursts until the job reports idle. Most requests
   // come from workers of the job; some come from any worker, and a burst now and
   // then opens with a start that must be refused while the job runs.
   task automatic drain(int unsigned crew);
      int unsigned burst;
      settle();
      while (!idle_seen && crew != 0) begin
         burst = $urandom_range(1, 4);
         if ($urandom_range(0, 19) == 0)
            issue(job(16'($urandom)));
         repeat (burst) begin
            if ($urandom_range(0, 7) == 0)
               issue(ask(3'($urandom)));
            else
               issue(ask(3'($urandom_range(0, crew - 1))));
         end
         settle();
      end
   endtask

   // Start a job and run it to the end.
   task automatic run_job(logic [15:0] count);
      int unsigned eff, crew;
      eff = (worker_setting == 0) ? 1 :
            (worker_setting > WORKERS_DEFAULT) ? WORKERS_DEFAULT : worker_setting;
      crew = (count < eff) ? count : eff;
      issue(job(count));
      drain(crew);
   endtask

   initial begin
      int unsigned jobs;
      int unsigned pick;
      logic [15:0] count;
      cfg_plan = '{4'd1, 4'd8, 4'd2, 4'd9, 4'd5, 4'd3, 4'd15, 4'd7, 4'd4, 4'd0, 4'd6};
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Requests from idle workers straight after reset: refuse both.
      issue(ask(3'd0));
      issue(ask(3'd7));
      // Empty job: started, nobody busy.
      issue(job(16'd0));
      // Three tasks over three workers; a second start and an outside worker get refused.
      issue(job(16'd3));
      issue(job(16'd5));
      issue(ask(3'd5));
      // Worker 0 drains its own task, steals the other two, then finishes; the rest finish.
      repeat (4) issue(ask(3'd0));
      issue(ask(3'd1));
      issue(ask(3'd2));
      // A worker count of 0 acts as one worker owning every task.
      set_workers(4'd0);
      issue(job(16'd4));
      repeat (5) issue(ask(3'd0));
      // A worker count above the maximum acts as the maximum; uneven split.
      set_workers(4'd15);
      issue(job(16'd19));
      issue(ask(3'd7));
      issue(ask(3'd3));
      drain(8);

      // Random jobs, mostly small, across a range of worker counts.
      jobs = 0;
      while (sent < 660) begin
         if (jobs % 4 == 0)
            set_workers((jobs / 4 < 11) ? cfg_plan[jobs / 4] : 4'($urandom_range(0, 15)));
         calm = (sent > 560);
         pick = $urandom_range(0, 9);
         count = (pick == 0) ? 16'd0 :
                 (pick < 3)  ? 16'($urandom_range(21, 60)) : 16'($urandom_range(1, 20));
         run_job(count);
         jobs++;
      end

      // Widest task count, left running after a handful of requests.
      set_workers(4'd15);
      issue(job(16'hFFFF));
      repeat (24) issue(ask(3'($urandom)));

      settle();
      repeat (20) @(negedge clock);
      if (fail_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Watchdog: end a hung run.
   initial begin
      #2000000;
      $display("tb: failure");
      $finish;
   end

endmodule
